FILE: sv/shdt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shdt_pkg
// shared types and constants of the string hash direct-mapped table
// ---------------------------------------------------------------------------
package shdt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int HANDLE_BITS = 16;
   localparam int CHAR_W      = 7;
   localparam int CSR_W       = 7;
   localparam int ACC_W       = 64;
   localparam int HALF_W      = ACC_W / 2;
   localparam int POS_W       = 32;
   localparam int MULT_W      = POS_W + 1;
   localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SIZE_W      = $clog2(TABLE_DEPTH + 1);
   localparam int EXT_W       = (CSR_W > SIZE_W) ? CSR_W : SIZE_W;
   localparam int CSR_RESET   = 64;

   // remainder unit: quotient bits retired per cycle
   localparam int MOD_BITS    = 4;
   localparam int MOD_STEPS   = ACC_W / MOD_BITS;
   localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

   localparam logic OP_PUT = 1'b0;
   localparam logic OP_GET = 1'b1;

   typedef struct packed {
      logic                   operation;
      logic [CHAR_W-1:0]      key_char;
      logic                   key_last;
      logic [HANDLE_BITS-1:0] put_handle;
   } req_type;

   typedef struct packed {
      logic                   found;
      logic [HANDLE_BITS-1:0] got_handle;
      logic [SLOT_W-1:0]      slot_index;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ADD,
      ST_MOD,
      ST_LOOKUP,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic load;
      logic mul_lo;
      logic mul_hi;
      logic add;
      logic mod_step;
      logic lookup;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic item_last;
      logic mod_done;
      logic rsp_free;
   } sts_type;

endpackage

FILE: sv/string_hash_direct_mapped_table.sv
`timescale 1ns / 1ps
// one request in flight; the 16-step remainder (4 bits a cycle)
//   and the two-pass 32x33 multiply set the per-key cost
// reset: synchronous, clears hash state, slot valid bits and table size to 64
// ---------------------------------------------------------------------------
// string_hash_direct_mapped_table
// character-serial key hash into a direct-mapped handle table (put / get)
// ---------------------------------------------------------------------------
module string_hash_direct_mapped_table (
   input  logic                       clock,
   input  logic                       reset,
   // request channel, one key character per request
   input  logic                       req_valid,
   output logic                       req_ready,
   input  shdt_pkg::req_type          req_data,
   // response channel, one response per key end
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output shdt_pkg::rsp_type          rsp_data,
   // table size register
   input  logic                       csr_we,
   input  logic [shdt_pkg::CSR_W-1:0] csr_wdata
);

   // command and status between sequencer and datapath
   shdt_pkg::cmd_type cmd;
   shdt_pkg::sts_type sts;

   // sequencer: idle -> multiply low half -> multiply high half -> add,
   // then on a key end remainder steps -> table access -> response
   shdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: 64-bit wrapping hash, shared multiplier, remainder unit,
   // 64-entry handle memory with valid bits, response register
   // the response register lets a new request in while a response waits
   shdt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

FILE: sv/shdt_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shdt_ctrl
// sequencer for hashing, remainder and table access
// ---------------------------------------------------------------------------
module shdt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  shdt_pkg::sts_type sts,
   output shdt_pkg::cmd_type cmd
);

   shdt_pkg::state_type state_ff;
   shdt_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= shdt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         shdt_pkg::ST_IDLE: begin
            if (req_valid) state_in = shdt_pkg::ST_MUL_LO;
         end
         shdt_pkg::ST_MUL_LO: state_in = shdt_pkg::ST_MUL_HI;
         shdt_pkg::ST_MUL_HI: state_in = shdt_pkg::ST_ADD;
         shdt_pkg::ST_ADD: begin
            state_in = sts.item_last ? shdt_pkg::ST_MOD : shdt_pkg::ST_IDLE;
         end
         shdt_pkg::ST_MOD: begin
            if (sts.mod_done) state_in = shdt_pkg::ST_LOOKUP;
         end
         shdt_pkg::ST_LOOKUP: state_in = shdt_pkg::ST_RESULT;
         shdt_pkg::ST_RESULT: begin
            if (sts.rsp_free) state_in = shdt_pkg::ST_IDLE;
         end
         default: state_in = shdt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         shdt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         shdt_pkg::ST_MUL_LO: cmd.mul_lo   = 1'b1;
         shdt_pkg::ST_MUL_HI: cmd.mul_hi   = 1'b1;
         shdt_pkg::ST_ADD:    cmd.add      = 1'b1;
         shdt_pkg::ST_MOD:    cmd.mod_step = 1'b1;
         shdt_pkg::ST_LOOKUP: cmd.lookup   = 1'b1;
         shdt_pkg::ST_RESULT: cmd.rsp_load = sts.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

FILE: sv/shdt_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shdt_dp
// hash accumulator, shared multiplier, remainder unit, slot table, response
// ---------------------------------------------------------------------------
module shdt_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  shdt_pkg::req_type                 req_data,
   input  logic                              csr_we,
   input  logic [shdt_pkg::CSR_W-1:0]        csr_wdata,
   output shdt_pkg::rsp_type                 rsp_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  shdt_pkg::cmd_type                 cmd,
   output shdt_pkg::sts_type                 sts
);

   localparam int DEPTH = shdt_pkg::TABLE_DEPTH;

   // table size, held already clamped to 1..depth
   logic [shdt_pkg::SIZE_W-1:0] size_ff;
   logic [shdt_pkg::SIZE_W-1:0] size_in;
   logic [shdt_pkg::EXT_W-1:0]  wdata_ext;

   // hash state
   logic [shdt_pkg::ACC_W-1:0]  acc_ff;
   logic [shdt_pkg::POS_W-1:0]  pos_ff;
   logic [shdt_pkg::MULT_W-1:0] mult_ff;
   logic [shdt_pkg::ACC_W-1:0]  prod_ff;
   logic [shdt_pkg::HALF_W-1:0] hi_ff;

   // latched item fields
   logic                             op_ff;
   logic                             last_ff;
   logic [shdt_pkg::HANDLE_BITS-1:0] handle_ff;

   // shared multiplier
   logic [shdt_pkg::HALF_W-1:0]               mul_a;
   logic [shdt_pkg::HALF_W+shdt_pkg::MULT_W-1:0] mul_full;

   // remainder unit
   logic [shdt_pkg::ACC_W-1:0]     div_ff;
   logic [shdt_pkg::SLOT_W-1:0]    rem_ff;
   logic [shdt_pkg::SLOT_W-1:0]    rem_in;
   logic [shdt_pkg::MOD_CNT_W-1:0] cnt_ff;

   // slot table
   logic [DEPTH-1:0]                 valid_ff;
   logic [shdt_pkg::HANDLE_BITS-1:0] mem [DEPTH];
   logic [shdt_pkg::HANDLE_BITS-1:0] rdata_ff;
   logic                             found_ff;

   logic              rsp_valid_ff;
   shdt_pkg::rsp_type rsp_data_ff;
   shdt_pkg::rsp_type rsp_data_in;

   always_comb begin
      wdata_ext = shdt_pkg::EXT_W'(csr_wdata);
      if (wdata_ext == '0) begin
         size_in = shdt_pkg::SIZE_W'(1);
      end else if (wdata_ext > shdt_pkg::EXT_W'(DEPTH)) begin
         size_in = shdt_pkg::SIZE_W'(DEPTH);
      end else begin
         size_in = shdt_pkg::SIZE_W'(wdata_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= shdt_pkg::SIZE_W'((shdt_pkg::CSR_RESET > DEPTH) ?
                                      DEPTH : shdt_pkg::CSR_RESET);
      end else if (csr_we) begin
         size_ff <= size_in;
      end
   end

   assign mul_a    = cmd.mul_hi ? acc_ff[shdt_pkg::ACC_W-1:shdt_pkg::HALF_W]
                                : acc_ff[shdt_pkg::HALF_W-1:0];
   assign mul_full = mul_a * mult_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         pos_ff <= '0;
      end else if (cmd.load) begin
         acc_ff <= acc_ff + shdt_pkg::ACC_W'(req_data.key_char);
         pos_ff <= pos_ff + shdt_pkg::POS_W'(1);
      end else if (cmd.add) begin
         if (last_ff) begin
            acc_ff <= '0;
            pos_ff <= '0;
         end else begin
            acc_ff <= prod_ff + {hi_ff, {shdt_pkg::HALF_W{1'b0}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mult_ff   <= shdt_pkg::MULT_W'(pos_ff) + shdt_pkg::MULT_W'(2);
         op_ff     <= req_data.operation;
         last_ff   <= req_data.key_last;
         handle_ff <= req_data.put_handle;
      end
      if (cmd.mul_lo) prod_ff <= mul_full[shdt_pkg::ACC_W-1:0];
      if (cmd.mul_hi) hi_ff   <= mul_full[shdt_pkg::HALF_W-1:0];
   end

   // restoring remainder, several dividend bits per cycle from the top
   always_comb begin
      logic [shdt_pkg::SLOT_W:0] r;
      r = {1'b0, rem_ff};
      for (int i = 0; i < shdt_pkg::MOD_BITS; i++) begin
         r = {r[shdt_pkg::SLOT_W-1:0], div_ff[shdt_pkg::ACC_W-1-i]};
         if (r >= (shdt_pkg::SLOT_W+1)'(size_ff)) begin
            r = r - (shdt_pkg::SLOT_W+1)'(size_ff);
         end
      end
      rem_in = r[shdt_pkg::SLOT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.add) begin
         cnt_ff <= '0;
      end else if (cmd.mod_step) begin
         cnt_ff <= cnt_ff + shdt_pkg::MOD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add) begin
         div_ff <= prod_ff + {hi_ff, {shdt_pkg::HALF_W{1'b0}}};
         rem_ff <= '0;
      end else if (cmd.mod_step) begin
         div_ff <= div_ff << shdt_pkg::MOD_BITS;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.lookup && op_ff == shdt_pkg::OP_PUT) begin
         valid_ff[rem_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         if (op_ff == shdt_pkg::OP_PUT) mem[rem_ff] <= handle_ff;
         rdata_ff <= mem[rem_ff];
         found_ff <= valid_ff[rem_ff];
      end
   end

   always_comb begin
      rsp_data_in.slot_index = rem_ff;
      if (op_ff == shdt_pkg::OP_PUT) begin
         rsp_data_in.found      = 1'b1;
         rsp_data_in.got_handle = handle_ff;
      end else begin
         rsp_data_in.found      = found_ff;
         rsp_data_in.got_handle = found_ff ? rdata_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;
   assign sts.item_last = last_ff;
   assign sts.mod_done  = (cnt_ff == shdt_pkg::MOD_CNT_W'(shdt_pkg::MOD_STEPS - 1));
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;

   a_no_handle_when_missing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.found |-> rsp_data_ff.got_handle == '0)
      else $error("response without a hit carries a handle");

   a_rem_below_size: assert property (@(posedge clock) disable iff (reset)
      cmd.mod_step |-> (shdt_pkg::SIZE_W'(rem_ff) < size_ff))
      else $error("partial remainder not below table size");

   a_key_end_clears_hash: assert property (@(posedge clock) disable iff (reset)
      cmd.add && last_ff |=> acc_ff == '0 && pos_ff == '0)
      else $error("hash state not cleared at key end");

endmodule

FILE: sim/tb_string_hash_direct_mapped_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_string_hash_direct_mapped_table
// self-checking bench for the string hash direct-mapped table: keys go in
// one character per request, a local hash and table model predicts every
// put / get response, and responses are checked field by field in order
// while both sides idle at random and the table size is changed between
// phases
// ---------------------------------------------------------------------------
module tb_string_hash_direct_mapped_table;

   localparam int KEY_POOL     = 16;
   localparam int MAX_KEY      = 30;
   localparam int SETTLE_WAIT  = 40;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 600;
   localparam int HOLD_AFTER   = 40;      // responses seen before the hold-off
   localparam int IDLE_PCT     = 7;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // block inputs, all known from time zero
   logic                           req_valid = 1'b0;
   shdt_pkg::req_type              req_data  = '0;
   logic                           rsp_ready = 1'b0;
   logic                           csr_we    = 1'b0;
   logic [shdt_pkg::CSR_W-1:0]     csr_wdata = '0;

   // block outputs
   logic                           req_ready;
   logic                           rsp_valid;
   shdt_pkg::rsp_type              rsp_data;

   // requests waiting to be offered, responses the model has predicted
   shdt_pkg::req_type              pending_reqs[$];
   shdt_pkg::rsp_type              lookup_results[$];

   // local copy of the hash state, the table and the size register
   logic [shdt_pkg::ACC_W-1:0]       hash_acc = '0;
   logic [shdt_pkg::POS_W-1:0]       char_pos = '0;
   logic                             slot_valid  [shdt_pkg::TABLE_DEPTH];
   logic [shdt_pkg::HANDLE_BITS-1:0] slot_handle [shdt_pkg::TABLE_DEPTH];
   logic [shdt_pkg::CSR_W-1:0]       table_size =
                                        shdt_pkg::CSR_W'(shdt_pkg::CSR_RESET);

   // key pool so that gets can find earlier puts
   logic [shdt_pkg::CHAR_W-1:0]    key_chars [KEY_POOL][MAX_KEY];
   int                             key_len   [KEY_POOL];

   int                   mismatches  = 0;
   int                   cycle_count = 0;
   int                   rsp_count   = 0;
   int                   hold_left   = 0;
   logic                 calm        = 1'b0;   // no random idling while set

   string_hash_direct_mapped_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < shdt_pkg::TABLE_DEPTH; i++) begin
         slot_valid[i]  = 1'b0;
         slot_handle[i] = '0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // one line per mismatch
   task automatic report_mismatch(input string what, input int unsigned seen,
                                  input int unsigned want);
      mismatches++;
      $display("[%0t] mismatch, %s: got %0h, expected %0h", $time, what, seen, want);
   endtask

   // hash one accepted character; on a key end, look up the table and
   // queue the response the block has to give
   task automatic hash_key_char(input shdt_pkg::req_type r);
      logic [shdt_pkg::ACC_W-1:0]  size;
      logic [shdt_pkg::ACC_W-1:0]  slot;
      logic [shdt_pkg::SLOT_W-1:0] idx;
      shdt_pkg::rsp_type           res;
      hash_acc = hash_acc + shdt_pkg::ACC_W'(r.key_char);
      hash_acc = hash_acc * ({32'd0, char_pos} + 64'd2);
      char_pos = char_pos + 32'd1;
      if (r.key_last) begin
         // size zero acts as one, sizes past the depth saturate
         if (table_size == 0) begin
            size = 64'd1;
         end else if (table_size > shdt_pkg::TABLE_DEPTH) begin
            size = shdt_pkg::ACC_W'(shdt_pkg::TABLE_DEPTH);
         end else begin
            size = shdt_pkg::ACC_W'(table_size);
         end
         slot     = hash_acc % size;
         idx      = slot[shdt_pkg::SLOT_W-1:0];
         hash_acc = '0;
         char_pos = '0;
         res.slot_index = idx;
         if (r.operation == shdt_pkg::OP_PUT) begin
            // a put overwrites whatever shares the slot
            slot_valid[idx]  = 1'b1;
            slot_handle[idx] = r.put_handle;
            res.found        = 1'b1;
            res.got_handle   = r.put_handle;
         end else begin
            res.found      = slot_valid[idx];
            res.got_handle = slot_valid[idx] ? slot_handle[idx] : '0;
         end
         lookup_results.push_back(res);
      end
   endtask

   // driver: offer the next request once the previous one is taken
   always @(posedge clock) begin : drive_requests
      shdt_pkg::req_type next_req;
      logic              next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_req   = req_data;
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            hash_key_char(req_data);
            next_valid = 1'b0;
         end
         if (!next_valid && pending_reqs.size() != 0 &&
             (calm || $urandom_range(99) >= IDLE_PCT)) begin
            next_req   = pending_reqs.pop_front();
            next_valid = 1'b1;
         end
         req_valid <= next_valid;
         req_data  <= next_req;
      end
   end

   // monitor: check each response against the oldest prediction
   always @(posedge clock) begin : check_responses
      shdt_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (lookup_results.size() == 0) begin
               report_mismatch("response with none predicted", 32'(rsp_data), 0);
            end else begin
               want = lookup_results.pop_front();
               if (rsp_data.found !== want.found)
                  report_mismatch("found", 32'(rsp_data.found), 32'(want.found));
               if (rsp_data.got_handle !== want.got_handle)
                  report_mismatch("got_handle", 32'(rsp_data.got_handle),
                                  32'(want.got_handle));
               if (rsp_data.slot_index !== want.slot_index)
                  report_mismatch("slot_index", 32'(rsp_data.slot_index),
                                  32'(want.slot_index));
            end
            rsp_count = rsp_count + 1;
            // long hold-off once, so the block backs up into its input
            if (rsp_count == HOLD_AFTER) hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // fill one pool entry with random characters
   task automatic make_key(input int which, input int len);
      key_len[which] = len;
      for (int i = 0; i < len; i++)
         key_chars[which][i] = shdt_pkg::CHAR_W'($urandom_range(1, 127));
   endtask

   // queue one whole key; fields off the last character are noise
   task automatic send_key(input int which, input logic op, input logic [15:0] handle);
      shdt_pkg::req_type r;
      for (int i = 0; i < key_len[which]; i++) begin
         r.key_char = key_chars[which][i];
         r.key_last = (i == key_len[which] - 1);
         if (r.key_last) begin
            r.operation  = op;
            r.put_handle = handle;
         end else begin
            r.operation  = 1'($urandom_range(1));
            r.put_handle = shdt_pkg::HANDLE_BITS'($urandom);
         end
         pending_reqs.push_back(r);
      end
   endtask

   // random keys, mostly reused from the pool so gets hit earlier puts
   task automatic random_keys(input int n_items);
      int sent;
      int which;
      int roll;
      int len;
      sent = 0;
      while (sent < n_items) begin
         which = $urandom_range(KEY_POOL - 1);
         if ($urandom_range(99) < 30) begin
            roll = $urandom_range(99);
            if (roll < 85)      len = $urandom_range(1, 6);
            else if (roll < 95) len = $urandom_range(7, 16);
            else                len = $urandom_range(17, MAX_KEY);  // accumulator wraps
            make_key(which, len);
         end
         send_key(which, 1'($urandom_range(1)), 16'($urandom));
         sent = sent + key_len[which];
      end
   endtask

   // drain: all requests taken, all responses seen, block back at rest
   task automatic settle();
      while (pending_reqs.size() != 0 || req_valid || lookup_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_size(input logic [shdt_pkg::CSR_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we     <= 1'b0;
      table_size = value;
   endtask

   // main sequence
   initial begin : main_sequence
      logic [shdt_pkg::CSR_W-1:0] sizes [8];
      sizes[0] = 7'd0;      // acts as a single slot
      sizes[1] = 7'd1;
      sizes[2] = 7'd127;    // saturates to the depth
      sizes[3] = 7'd5;
      sizes[4] = 7'd64;
      sizes[5] = 7'd65;
      sizes[6] = shdt_pkg::CSR_W'($urandom_range(2, 63));
      sizes[7] = shdt_pkg::CSR_W'($urandom_range(1, 127));
      for (int i = 0; i < KEY_POOL; i++) make_key(i, $urandom_range(1, 6));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed keys at the reset size
      key_len[0] = 1;  key_chars[0][0] = 7'd127;
      key_len[1] = 1;  key_chars[1][0] = 7'd1;
      key_len[2] = 3;
      key_chars[2][0] = 7'd127;  key_chars[2][1] = 7'd1;  key_chars[2][2] = 7'd127;
      // a zero character is hashed, it does not end the key
      key_len[3] = 3;
      key_chars[3][0] = 7'd65;   key_chars[3][1] = 7'd0;  key_chars[3][2] = 7'd66;
      send_key(0, shdt_pkg::OP_PUT, 16'hffff);
      send_key(0, shdt_pkg::OP_GET, 16'h0000);
      send_key(1, shdt_pkg::OP_GET, 16'hffff);      // empty slot
      send_key(1, shdt_pkg::OP_PUT, 16'h0000);
      send_key(1, shdt_pkg::OP_GET, 16'h1234);      // found, handle zero
      send_key(2, shdt_pkg::OP_PUT, 16'h5a5a);
      send_key(2, shdt_pkg::OP_GET, 16'h0000);
      send_key(3, shdt_pkg::OP_GET, 16'h0000);
      send_key(3, shdt_pkg::OP_PUT, 16'ha5a5);
      random_keys(300);
      settle();

      for (int p = 0; p < 8; p++) begin
         write_size(sizes[p]);
         if (p == 2) calm <= 1'b1;        // one phase with no idling at all
         random_keys(215);
         settle();
         calm <= 1'b0;
      end

      if (lookup_results.size() != 0)
         report_mismatch("responses never seen", 32'(lookup_results.size()), 0);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
